>>> hw/rtl/tsrs_pkg.sv
// ---------------------------------------------------------------------------
// tsrs_pkg
// Shared types, register indexes and time helpers for the time sync retry
// scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package tsrs_pkg;

  // Width of the free running millisecond time and of all time differences
  localparam int TimeW = 32;

  typedef logic [TimeW-1:0] ms_t;
  typedef logic [31:0]      utc_t;
  typedef logic [7:0]       cnt_t;

  // Result codes
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_SUCCESS = 2'd2,
    ACT_TIMEOUT = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STABLE_DELAY   = 3'd0,
    REG_BOOT_RETRY     = 3'd1,
    REG_BOOT_MAX       = 3'd2,
    REG_ROUTINE_PERIOD = 3'd3,
    REG_TOUR_COUNT     = 3'd4,
    REG_ATTEMPT_TMO    = 3'd5,
    REG_MIN_VALID      = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam ms_t  StableDelayRst   = ms_t'(120000);
  localparam ms_t  BootRetryRst     = ms_t'(30000);
  localparam cnt_t BootMaxRst       = cnt_t'(10);
  localparam ms_t  RoutinePeriodRst = ms_t'(3000000);
  localparam cnt_t TourCountRst     = cnt_t'(1);
  localparam ms_t  AttemptTmoRst    = ms_t'(10000);
  localparam utc_t MinValidRst      = utc_t'(1700000000);

  typedef struct packed {
    ms_t  stable_delay_ms;
    ms_t  boot_retry_ms;
    cnt_t boot_attempt_limit;
    ms_t  routine_period_ms;
    cnt_t routine_tour_count;
    ms_t  attempt_timeout_ms;
    utc_t min_valid_time;
  } sched_cfg_t;

  typedef struct packed {
    logic attempt_pending;
    logic synced_once;
    ms_t  link_up_since;
    ms_t  last_boot_attempt;
    ms_t  last_tour_start;
    cnt_t boot_attempts;
    cnt_t tour_counter;
    ms_t  attempt_start;
  } sched_state_t;

  typedef struct packed {
    ms_t  now_ms;
    logic link_up;
    logic clock_available;
    utc_t utc_now;
  } tick_t;

  typedef struct packed {
    action_t action;
    utc_t    sync_time;
  } sched_res_t;

  // Wrapping difference of two millisecond times
  function automatic ms_t elapsed(input ms_t now, input ms_t then);
    elapsed = now - then;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tsrs_decide.sv
// ---------------------------------------------------------------------------
// tsrs_decide
// Combinational per-tick decision: next scheduler state and the result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tsrs_decide (
  input  wire tsrs_pkg::sched_cfg_t   cfg,
  input  wire tsrs_pkg::sched_state_t st,
  input  wire tsrs_pkg::tick_t        tick,
  output tsrs_pkg::sched_state_t      st_next,
  output tsrs_pkg::sched_res_t        res
);
  import tsrs_pkg::*;

  cnt_t tour_inc;

  always_comb begin
    st_next       = st;
    res.action    = ACT_NONE;
    res.sync_time = '0;
    tour_inc      = st.tour_counter + cnt_t'(1);

    if (st.attempt_pending) begin
      // Pending attempt: success wins over timeout
      if (tick.utc_now >= cfg.min_valid_time) begin
        st_next.attempt_pending = 1'b0;
        st_next.synced_once     = 1'b1;
        st_next.last_tour_start = tick.now_ms;
        res.action              = ACT_SUCCESS;
        res.sync_time           = tick.utc_now;
      end else if (elapsed(tick.now_ms, st.attempt_start) >= cfg.attempt_timeout_ms) begin
        st_next.attempt_pending = 1'b0;
        res.action              = ACT_TIMEOUT;
      end
    end else if (!tick.link_up) begin
      // Link down: forget when it came up
      st_next.link_up_since = '0;
    end else begin
      // Latch link-up time and restart the boot phase
      if (st.link_up_since == '0) begin
        st_next.link_up_since     = tick.now_ms;
        st_next.last_boot_attempt = '0;
        st_next.boot_attempts     = '0;
      end
      if (elapsed(tick.now_ms, st_next.link_up_since) >= cfg.stable_delay_ms) begin
        if (!st.synced_once && (st_next.boot_attempts < cfg.boot_attempt_limit)) begin
          // Boot phase: fast attempts at the boot spacing
          if (elapsed(tick.now_ms, st_next.last_boot_attempt) >= cfg.boot_retry_ms) begin
            st_next.last_boot_attempt = tick.now_ms;
            st_next.boot_attempts     = st_next.boot_attempts + cnt_t'(1);
            st_next.attempt_pending   = 1'b1;
            st_next.attempt_start     = tick.now_ms;
            res.action                = ACT_START;
          end
        end else if (elapsed(tick.now_ms, st.last_tour_start) >= cfg.routine_period_ms) begin
          // Routine phase: one tour has ended
          st_next.last_tour_start = tick.now_ms;
          if (!tick.clock_available) begin
            st_next.attempt_pending = 1'b1;
            st_next.attempt_start   = tick.now_ms;
            res.action              = ACT_START;
          end else begin
            st_next.tour_counter = tour_inc;
            if (tour_inc >= cfg.routine_tour_count) begin
              st_next.tour_counter    = '0;
              st_next.attempt_pending = 1'b1;
              st_next.attempt_start   = tick.now_ms;
              res.action              = ACT_START;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/time_sync_retry_scheduler.sv
// ---------------------------------------------------------------------------
// time_sync_retry_scheduler
// Decides per poll tick whether to start, succeed or abandon a time sync
// attempt, with a boot phase of fast retries and a slower routine phase.
// ---------------------------------------------------------------------------
// Each accepted input beat is one poll tick and yields exactly one result
// beat. A tick is captured in an input register, decided combinationally in
// the single decision stage that owns the scheduler state and held in the
// output register. A new tick is taken every cycle while the output register
// is free or drains; a stall on the output side holds back the input.
// Configuration registers take one write per cycle (cfg_ready is always
// high) and should be changed only while no tick is in flight.
// Reset restores the default delays, retry counts and valid-time threshold.
`default_nettype none

module time_sync_retry_scheduler (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  // poll ticks
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tsrs_pkg::ms_t     now_ms,
  input  wire logic              link_up,
  input  wire logic              clock_available,
  input  wire tsrs_pkg::utc_t    utc_now,
  // results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsrs_pkg::action_t      action,
  output tsrs_pkg::utc_t         sync_time,
  output logic                   ever_synced,
  output tsrs_pkg::cnt_t         boot_attempt_count
);
  import tsrs_pkg::*;

  sched_cfg_t   cfg;
  sched_state_t st;
  sched_state_t st_next;
  sched_res_t   res;
  tick_t        s1;
  logic         s1_valid;
  logic         advance;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_delay_ms    <= StableDelayRst;
      cfg.boot_retry_ms      <= BootRetryRst;
      cfg.boot_attempt_limit <= BootMaxRst;
      cfg.routine_period_ms  <= RoutinePeriodRst;
      cfg.routine_tour_count <= TourCountRst;
      cfg.attempt_timeout_ms <= AttemptTmoRst;
      cfg.min_valid_time     <= MinValidRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STABLE_DELAY:   cfg.stable_delay_ms    <= ms_t'(cfg_data);
        REG_BOOT_RETRY:     cfg.boot_retry_ms      <= ms_t'(cfg_data);
        REG_BOOT_MAX:       cfg.boot_attempt_limit <= cfg_data[7:0];
        REG_ROUTINE_PERIOD: cfg.routine_period_ms  <= ms_t'(cfg_data);
        REG_TOUR_COUNT:     cfg.routine_tour_count <= cfg_data[7:0];
        REG_ATTEMPT_TMO:    cfg.attempt_timeout_ms <= ms_t'(cfg_data);
        REG_MIN_VALID:      cfg.min_valid_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the decision stage when the output register is free or drains
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.now_ms          <= now_ms;
      s1.link_up         <= link_up;
      s1.clock_available <= clock_available;
      s1.utc_now         <= utc_now;
    end
  end

  tsrs_decide u_decide (
    .cfg     (cfg),
    .st      (st),
    .tick    (s1),
    .st_next (st_next),
    .res     (res)
  );

  // Scheduler state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      action             <= res.action;
      sync_time          <= res.sync_time;
      ever_synced        <= st_next.synced_once;
      boot_attempt_count <= st_next.boot_attempts;
    end
  end

  // Success is only reported with the synced flag set
  a_success_synced: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_SUCCESS) |-> ever_synced)
    else $error("success reported without ever_synced");

  // Sync time is zero except on success
  a_sync_time_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_SUCCESS) |-> (sync_time == '0))
    else $error("nonzero sync_time without success");

  // Once synced, stay synced
  a_synced_sticky: assert property (@(posedge clk) disable iff (rst)
    st.synced_once |=> st.synced_once)
    else $error("synced flag dropped");

  // A started attempt leaves an attempt pending
  a_start_pending: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && (res.action == ACT_START) |=> st.attempt_pending)
    else $error("attempt started but not pending");

  // No new attempt starts while one is pending
  a_no_double_start: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && st.attempt_pending |-> (res.action != ACT_START))
    else $error("attempt started while one pending");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time sync retry scheduler. A queue-fed driver
// offers poll ticks in random bursts, a monitor drains results under its own
// stall pattern, and a cycle-free scheduler model predicts every result beat.
// Several register settings are applied between drained phases, from all
// zeros to all ones, with directed ticks first and random tick streams after.
// ---------------------------------------------------------------------------
module tb_top;
  import tsrs_pkg::*;

  localparam logic [2:0] RegSpare = 3'd7;   // unmapped index, must be ignored

  typedef struct packed {
    action_t action;
    utc_t    sync_time;
    logic    ever_synced;
    cnt_t    boot_count;
  } sync_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  logic    in_valid        = 1'b0;
  logic    in_ready;
  ms_t     now_ms          = '0;
  logic    link_up         = 1'b0;
  logic    clock_available = 1'b0;
  utc_t    utc_now         = '0;

  logic    out_valid;
  logic    out_ready = 1'b0;
  action_t action;
  utc_t    sync_time;
  logic    ever_synced;
  cnt_t    boot_attempt_count;

  time_sync_retry_scheduler DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .now_ms             (now_ms),
    .link_up            (link_up),
    .clock_available    (clock_available),
    .utc_now            (utc_now),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .action             (action),
    .sync_time          (sync_time),
    .ever_synced        (ever_synced),
    .boot_attempt_count (boot_attempt_count)
  );

  initial forever #2 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Scheduler model: configuration copy
  ms_t  cfg_stable     = StableDelayRst;
  ms_t  cfg_boot_retry = BootRetryRst;
  cnt_t cfg_boot_max   = BootMaxRst;
  ms_t  cfg_period     = RoutinePeriodRst;
  cnt_t cfg_tours      = TourCountRst;
  ms_t  cfg_timeout    = AttemptTmoRst;
  utc_t cfg_min_valid  = MinValidRst;

  // Scheduler model: state copy
  logic sch_pending   = 1'b0;
  logic sch_synced    = 1'b0;
  ms_t  sch_up_since  = '0;
  ms_t  sch_last_boot = '0;
  ms_t  sch_last_tour = '0;
  cnt_t sch_boot_cnt  = '0;
  cnt_t sch_tour_cnt  = '0;
  ms_t  sch_att_start = '0;

  tick_t         tick_backlog[$];
  sync_outcome_t pending_outcomes[$];

  int ticks_queued    = 0;
  int ticks_sent      = 0;
  int results_checked = 0;
  int error_count     = 0;
  int n_start         = 0;
  int n_success       = 0;
  int n_timeout       = 0;
  int settings_used   = 0;

  function automatic ms_t ms_gap(input ms_t later, input ms_t earlier);
    ms_gap = later - earlier;
  endfunction

  // Advance the model by one tick and queue the result it implies
  task automatic predict_sync_tick(input tick_t t);
    sync_outcome_t o;
    o.action    = ACT_NONE;
    o.sync_time = '0;
    if (sch_pending) begin
      if (t.utc_now >= cfg_min_valid) begin
        sch_pending   = 1'b0;
        sch_synced    = 1'b1;
        sch_last_tour = t.now_ms;
        o.action      = ACT_SUCCESS;
        o.sync_time   = t.utc_now;
      end else if (ms_gap(t.now_ms, sch_att_start) >= cfg_timeout) begin
        sch_pending = 1'b0;
        o.action    = ACT_TIMEOUT;
      end
    end else if (!t.link_up) begin
      sch_up_since = '0;
    end else begin
      // latch the link-up time, zero meaning down
      if (sch_up_since == '0) begin
        sch_up_since  = t.now_ms;
        sch_last_boot = '0;
        sch_boot_cnt  = '0;
      end
      if (ms_gap(t.now_ms, sch_up_since) >= cfg_stable) begin
        if (!sch_synced && sch_boot_cnt < cfg_boot_max) begin
          if (ms_gap(t.now_ms, sch_last_boot) >= cfg_boot_retry) begin
            sch_last_boot = t.now_ms;
            sch_boot_cnt  = sch_boot_cnt + 8'd1;
            sch_att_start = t.now_ms;
            sch_pending   = 1'b1;
            o.action      = ACT_START;
          end
        end else if (ms_gap(t.now_ms, sch_last_tour) >= cfg_period) begin
          sch_last_tour = t.now_ms;
          if (!t.clock_available) begin
            sch_att_start = t.now_ms;
            sch_pending   = 1'b1;
            o.action      = ACT_START;
          end else begin
            sch_tour_cnt = sch_tour_cnt + 8'd1;
            if (sch_tour_cnt >= cfg_tours) begin
              sch_tour_cnt  = '0;
              sch_att_start = t.now_ms;
              sch_pending   = 1'b1;
              o.action      = ACT_START;
            end
          end
        end
      end
    end
    o.ever_synced = sch_synced;
    o.boot_count  = sch_boot_cnt;
    pending_outcomes.push_back(o);
  endtask

  // Driver: offer queued ticks in bursts separated by random gaps
  tick_t cur_tick;
  int    burst_left = 1;
  int    gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sync_tick(cur_tick);
        ticks_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || tick_backlog.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          cur_tick = tick_backlog.pop_front();
          in_valid        <= 1'b1;
          now_ms          <= cur_tick.now_ms;
          link_up         <= cur_tick.link_up;
          clock_available <= cur_tick.clock_available;
          utc_now         <= cur_tick.utc_now;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: check each result beat, then pick the next ready value
  int rx_cycle       = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;

  task automatic report_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    error_count++;
  endtask

  always @(posedge clk) begin
    sync_outcome_t o;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual action %0d time %0d",
                   $time, action, sync_time);
          error_count++;
        end else begin
          o = pending_outcomes.pop_front();
          if (action != o.action) report_field("action", 32'(o.action), 32'(action));
          if (sync_time != o.sync_time) report_field("sync_time", o.sync_time, sync_time);
          if (ever_synced != o.ever_synced)
            report_field("ever_synced", 32'(o.ever_synced), 32'(ever_synced));
          if (boot_attempt_count != o.boot_count)
            report_field("boot_attempt_count", 32'(o.boot_count), 32'(boot_attempt_count));
          case (o.action)
            ACT_START:   n_start++;
            ACT_SUCCESS: n_success++;
            ACT_TIMEOUT: n_timeout++;
            default: ;
          endcase
          results_checked++;
        end
      end
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_checked >= 400 && tick_backlog.size() > 20) begin
        // hold off long enough to back up the block while ticks keep coming
        hold_left      = 250;
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle >> 6) & 3)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ((rx_cycle & 3) != 3);
          2:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= rx_cycle[2];
        endcase
      end
    end
  end

  // Stimulus helpers
  ms_t  gen_now  = '0;
  logic gen_link = 1'b1;
  logic gen_clk  = 1'b0;

  task automatic push_tick(input ms_t t_now, input logic t_link, input logic t_clk,
                           input utc_t t_utc);
    tick_t t;
    t.now_ms          = t_now;
    t.link_up         = t_link;
    t.clock_available = t_clk;
    t.utc_now         = t_utc;
    tick_backlog.push_back(t);
    ticks_queued++;
  endtask

  // Hold until every queued tick has been taken and every result checked
  task automatic wait_drained();
    while (ticks_sent != ticks_queued || pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; called at a clock edge, returns at the accepting edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STABLE_DELAY:   cfg_stable     = data;
      REG_BOOT_RETRY:     cfg_boot_retry = data;
      REG_BOOT_MAX:       cfg_boot_max   = data[7:0];
      REG_ROUTINE_PERIOD: cfg_period     = data;
      REG_TOUR_COUNT:     cfg_tours      = data[7:0];
      REG_ATTEMPT_TMO:    cfg_timeout    = data;
      REG_MIN_VALID:      cfg_min_valid  = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input ms_t stable, input ms_t retry, input cnt_t bmax,
                                input ms_t period, input cnt_t tours, input ms_t tmo,
                                input utc_t minv);
    write_reg(REG_STABLE_DELAY, stable);
    write_reg(REG_BOOT_RETRY, retry);
    write_reg(REG_BOOT_MAX, {24'($urandom), bmax});
    write_reg(REG_ROUTINE_PERIOD, period);
    write_reg(REG_TOUR_COUNT, {24'($urandom), tours});
    write_reg(REG_ATTEMPT_TMO, tmo);
    write_reg(REG_MIN_VALID, minv);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly steady link with advancing time, plus jumps, drops and odd values
  task automatic gen_ticks(input int count, input ms_t step_max);
    int   r;
    utc_t u;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4)      gen_now = $urandom;
      else if (r < 6) gen_now = '0;
      else            gen_now = gen_now + ms_t'($urandom_range(0, step_max));
      if (gen_link) gen_link = ($urandom_range(0, 99) >= 3);
      else          gen_link = ($urandom_range(0, 99) < 40);
      if ($urandom_range(0, 99) < 5) gen_clk = ~gen_clk;
      r = $urandom_range(0, 99);
      if (r < 20)                   u = $urandom_range(cfg_min_valid, 32'hFFFF_FFFF);
      else if (r < 25 || cfg_min_valid == '0) u = $urandom;
      else                          u = $urandom_range(0, cfg_min_valid - 1);
      push_tick(gen_now, gen_link, gen_clk, u);
    end
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under reset settings
    push_tick(32'd100, 1'b0, 1'b0, 32'd0);                  // link down
    push_tick(32'd0, 1'b1, 1'b0, 32'd0);                    // link up at time zero
    push_tick(32'd50, 1'b1, 1'b0, 32'd0);                   // latched again
    push_tick(32'd120050, 1'b1, 1'b0, 32'd0);               // stable: boot attempt
    push_tick(32'd121000, 1'b0, 1'b1, 32'd0);               // pending ignores link
    push_tick(32'd130050, 1'b1, 1'b0, 32'd5);               // attempt times out
    push_tick(32'd150050, 1'b1, 1'b0, 32'd0);               // next boot attempt
    push_tick(32'd150060, 1'b1, 1'b0, 32'hFFFF_FFFF);       // success, max utc
    push_tick(32'd150070, 1'b1, 1'b1, 32'd0);               // routine not yet due
    push_tick(32'd3150060, 1'b1, 1'b0, 32'd0);              // routine start
    push_tick(32'd3150061, 1'b1, 1'b0, 32'd1700000000);     // success at threshold
    push_tick(32'd6150061, 1'b1, 1'b1, 32'd0);              // tour with clock valid
    push_tick(32'd6900000, 1'b1, 1'b1, 32'd1700000001);     // success beats timeout
    push_tick(32'd6900100, 1'b0, 1'b0, 32'd0);              // drop the link
    push_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF);    // up at max time
    push_tick(32'd119999, 1'b1, 1'b1, 32'd0);               // stable across the wrap
    push_tick(32'd0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    push_tick(32'd5, 1'b1, 1'b0, 32'h5555_5555);
    push_tick(32'd200000, 1'b1, 1'b0, 32'hAAAA_AAAA);
    push_tick(32'd200001, 1'b1, 1'b1, 32'h0000_0001);
    gen_now = 32'd200001;
    gen_ticks(60, 32'd40000);
    wait_drained();

    // Small fixed settings, plus a write to the unmapped index
    write_reg(RegSpare, $urandom);
    apply_settings(32'd40, 32'd15, 8'd4, 32'd60, 8'd3, 32'd25, 32'd1000);
    gen_ticks(150, 32'd20);
    wait_drained();

    // All zero: boot phase skipped, every tour attempts, every attempt succeeds
    apply_settings('0, '0, '0, '0, '0, '0, '0);
    gen_ticks(100, 32'd5);
    wait_drained();

    // All ones
    apply_settings('1, '1, '1, '1, '1, '1, '1);
    gen_ticks(60, 32'hFFFF_FFFF);
    wait_drained();

    // Random small settings
    for (int p = 0; p < 5; p++) begin
      apply_settings($urandom_range(0, 80), $urandom_range(0, 40),
                     cnt_t'($urandom_range(0, 12)), $urandom_range(0, 150),
                     cnt_t'($urandom_range(0, 6)), $urandom_range(0, 40),
                     $urandom_range(0, 2000));
      gen_ticks(130, 32'd30);
      wait_drained();
    end

    // Back to the reset values
    apply_settings(StableDelayRst, BootRetryRst, BootMaxRst, RoutinePeriodRst,
                   TourCountRst, AttemptTmoRst, MinValidRst);
    gen_ticks(60, 32'd40000);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Summary: %0d poll ticks checked under %0d register settings", results_checked,
             settings_used);
    $display("Summary: %0d attempts started, %0d succeeded, %0d timed out", n_start,
             n_success, n_timeout);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tsrs_pkg.sv
hw/rtl/tsrs_decide.sv
hw/rtl/time_sync_retry_scheduler.sv
test/tb_top.sv
